@@ rtl/core/ccfl_pkg.sv @@
package ccfl_pkg;

    localparam int FRAME_W_MAX = 24;
    localparam int COLOR_W_MAX = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int COUNT_W     = 17;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic        any_color;
        logic [2:0]  want_color;
        logic [15:0] frame_index;
    } t_in_word;

    typedef struct packed {
        logic               ok;
        logic [15:0]        got_frame;
        logic [2:0]         got_color;
        logic [COUNT_W-1:0] free_total;
    } t_out_word;

    typedef struct packed {
        logic                   is_free;
        logic                   any_color;
        logic [COLOR_W_MAX-1:0] color;
        logic [FRAME_W_MAX-1:0] frame;
    } t_job;

endpackage

@@ rtl/core/ccfl_ram.sv @@
module ccfl_ram
    #(
        parameter int WIDTH = 17,
        parameter int DEPTH = 65536
    )
    (
        input  logic                     i_clk,
        input  logic                     i_we,
        input  logic [$clog2(DEPTH)-1:0] i_waddr,
        input  logic [WIDTH-1:0]         i_wdata,
        input  logic [$clog2(DEPTH)-1:0] i_raddr,
        output logic [WIDTH-1:0]         o_rdata
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/ccfl_front.sv @@
module ccfl_front
    import ccfl_pkg::*;
    #(
        parameter int NUM_COLORS = 8,
        parameter int FRAME_BITS = 16
    )
    (
        input  logic     i_clk,
        input  logic     i_rst_n,
        input  logic     start,
        output logic     busy,
        input  t_in_word i_word,
        output logic     o_job_valid,
        output t_job     o_job,
        input  logic     i_job_pop
    );

    localparam int CW = $clog2(NUM_COLORS);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [CW-1:0] CMASK = CW'(NUM_COLORS - 1);

    t_job                   job_in;
    logic [FRAME_W_MAX-1:0] frame_ext;
    logic [COLOR_W_MAX-1:0] want_ext;
    logic [CW-1:0]          color;
    logic                   push;

    t_job           r_q [QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [PW:0]    r_cnt;

    // classify: color of a freed frame from its low bits, else the masked request
    always_comb begin
        frame_ext = FRAME_W_MAX'(i_word.frame_index);
        frame_ext = FRAME_W_MAX'(frame_ext[FRAME_BITS-1:0]);
        want_ext  = COLOR_W_MAX'(i_word.want_color);
        if (i_word.cmd == CMD_FREE) begin
            color = frame_ext[CW-1:0] & CMASK;
        end else begin
            color = want_ext[CW-1:0] & CMASK;
        end
        job_in.is_free   = (i_word.cmd == CMD_FREE);
        job_in.any_color = i_word.any_color;
        job_in.color     = COLOR_W_MAX'(color);
        job_in.frame     = frame_ext;
    end

    assign busy        = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign push        = start && !busy;
    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wptr] <= job_in;
        end
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_job_pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push) - (PW+1)'(i_job_pop);
        end
    end

endmodule

@@ rtl/core/ccfl_back.sv @@
module ccfl_back
    import ccfl_pkg::*;
    #(
        parameter int NUM_COLORS = 8,
        parameter int FRAME_BITS = 16
    )
    (
        input  logic      i_clk,
        input  logic      i_rst_n,
        input  logic      i_job_valid,
        input  t_job      i_job,
        output logic      o_job_pop,
        output logic      o_done,
        output t_out_word o_result
    );

    localparam int CW = $clog2(NUM_COLORS);
    localparam logic [CW-1:0] CMASK = CW'(NUM_COLORS - 1);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state                 r_state;
    logic [FRAME_BITS-1:0]  r_head [NUM_COLORS];
    logic [NUM_COLORS-1:0]  r_hv;
    logic [CW-1:0]          r_rr;
    logic [COUNT_W-1:0]     r_count;
    logic [CW-1:0]          r_pop_color;
    logic [FRAME_BITS-1:0]  r_got;
    logic                   r_done;
    t_out_word              r_result;

    logic [CW-1:0]          job_color;
    logic [CW-1:0]          probe;
    logic [CW-1:0]          sel;
    logic                   found;
    logic [CW-1:0]          op_color;
    logic [FRAME_BITS-1:0]  head_rd;
    logic [FRAME_BITS-1:0]  job_frame;
    logic                   ram_we;
    logic [FRAME_BITS:0]    ram_rdata;
    logic [COUNT_W-1:0]     count_inc;
    logic [COUNT_W-1:0]     count_dec;

    assign job_color = i_job.color[CW-1:0];
    assign job_frame = i_job.frame[FRAME_BITS-1:0];
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;

    // round-robin probe: the lowest offset from r_rr with a non-empty list wins
    always_comb begin
        found = 1'b0;
        sel   = job_color;
        probe = '0;
        if (i_job.any_color) begin
            for (int k = NUM_COLORS - 1; k >= 0; k--) begin
                probe = (r_rr + CW'(k)) & CMASK;
                if (r_hv[probe]) begin
                    found = 1'b1;
                    sel   = probe;
                end
            end
        end else begin
            found = r_hv[job_color];
        end
    end

    assign op_color  = i_job.is_free ? job_color : sel;
    assign head_rd   = r_head[op_color];
    assign ram_we    = o_job_pop && i_job.is_free;
    assign count_inc = (r_count == COUNT_MAX) ? COUNT_MAX : r_count + 1'b1;
    assign count_dec = (r_count == '0) ? '0 : r_count - 1'b1;

    ccfl_ram #(
        .WIDTH (FRAME_BITS + 1),
        .DEPTH (2 ** FRAME_BITS)
    ) u_link (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (job_frame),
        .i_wdata ({r_hv[job_color], head_rd}),
        .i_raddr (head_rd),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hv    <= '0;
            r_rr    <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        if (i_job.is_free) begin
                            r_head[job_color]   <= job_frame;
                            r_hv[job_color]     <= 1'b1;
                            r_count             <= count_inc;
                            r_done              <= 1'b1;
                            r_result.ok         <= 1'b1;
                            r_result.got_frame  <= '0;
                            r_result.got_color  <= 3'(COLOR_W_MAX'(job_color));
                            r_result.free_total <= count_inc;
                        end else if (found) begin
                            if (i_job.any_color) begin
                                r_rr <= (sel + 1'b1) & CMASK;
                            end
                            r_pop_color <= sel;
                            r_got       <= head_rd;
                            r_state     <= S_POP;
                        end else begin
                            r_done              <= 1'b1;
                            r_result.ok         <= 1'b0;
                            r_result.got_frame  <= '0;
                            r_result.got_color  <= i_job.any_color ? 3'd0
                                                   : 3'(COLOR_W_MAX'(job_color));
                            r_result.free_total <= r_count;
                        end
                    end
                end
                S_POP: begin
                    r_head[r_pop_color] <= ram_rdata[FRAME_BITS-1:0];
                    r_hv[r_pop_color]   <= ram_rdata[FRAME_BITS];
                    r_count             <= count_dec;
                    r_done              <= 1'b1;
                    r_result.ok         <= 1'b1;
                    r_result.got_frame  <= 16'(FRAME_W_MAX'(r_got));
                    r_result.got_color  <= 3'(COLOR_W_MAX'(r_pop_color));
                    r_result.free_total <= count_dec;
                    r_state             <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    a_pop_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |=> o_done && o_result.ok)
        else $error("pop did not complete with ok");

    a_fail_zero_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.ok |-> o_result.got_frame == '0)
        else $error("failed allocate returned a frame");

    a_pop_from_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE && o_job_pop && !i_job.is_free && found |-> r_hv[sel])
        else $error("pop from empty list");

    a_no_pop_in_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_POP |-> !o_job_pop)
        else $error("queue popped while link read pending");

endmodule

@@ rtl/core/colored_frame_free_list_allocator_unit.sv @@
// Page-frame allocator, one LIFO free list per cache color.
// Input: a word is taken at a clock edge where start is high and busy is low.
//   cmd=1 frees frame_index onto the list of its low-bit color.
//   cmd=0 allocates from want_color, or with any_color=1 from the first
//   non-empty color in round-robin order.
// Output: one result word per input word, on o_result for one cycle with
//   o_done high. The receiver cannot stall; every result is taken.
// Words pass through a two-entry queue to the execution stage, so busy is
//   high only while the queue is full.
// Frees and failed allocates finish in S_IDLE, so the back end takes one such
//   word per cycle; a successful allocate also passes through S_POP, where no
//   new word is taken, since the registered read of the link memory must
//   return before the list head can be updated.
// Reset (synchronous, active low) empties all lists, clears the free count
//   and the round-robin pointer and drops queued words. Link memory contents
//   are not cleared.
module colored_frame_free_list_allocator_unit
    import ccfl_pkg::*;
    #(
        parameter int NUM_COLORS = 8,
        parameter int FRAME_BITS = 16
    )
    (
        input  logic      i_clk,
        input  logic      i_rst_n,
        input  logic      start,
        output logic      busy,
        input  t_in_word  i_word,
        output logic      o_done,
        output t_out_word o_result
    );

    logic job_valid;
    logic job_pop;
    t_job job;

    ccfl_front #(
        .NUM_COLORS (NUM_COLORS),
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_word      (i_word),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_pop   (job_pop)
    );

    ccfl_back #(
        .NUM_COLORS (NUM_COLORS),
        .FRAME_BITS (FRAME_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_pop   (job_pop),
        .o_done      (o_done),
        .o_result    (o_result)
    );

endmodule
